@@ rtl/gae_pkg.sv @@
package gae_pkg;

   localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

   localparam logic [2:0] FUNC_LOAD_POS = 3'd0;
   localparam logic [2:0] FUNC_LOAD_VEL = 3'd1;
   localparam logic [2:0] FUNC_ADD_BODY = 3'd2;
   localparam logic [2:0] FUNC_COMMIT   = 3'd3;
   localparam logic [2:0] FUNC_MOVE     = 3'd4;

   localparam logic [7:0] CSR_TIME_STEP = 8'd0;
   localparam logic [7:0] CSR_CAN_MOVE  = 8'd1;

   localparam logic [31:0] TIME_STEP_RESET = 32'h0001_0000;

   typedef struct packed {
      logic start;
      logic clear;
   } mul_req_type;

   function automatic logic [63:0] mag_of(input logic [63:0] x);
      return x[63] ? (64'd0 - x) : x;
   endfunction

   function automatic logic [63:0] from_mag(input logic neg, input logic [63:0] m);
      if (neg) begin
         return m[63] ? SMIN : (64'd0 - m);
      end
      return m[63] ? SMAX : m;
   endfunction

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         return a[63] ? SMIN : SMAX;
      end
      return s;
   endfunction

   function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] d;
      d = a - b;
      if (a[63] != b[63] && d[63] != a[63]) begin
         return a[63] ? SMIN : SMAX;
      end
      return d;
   endfunction

endpackage

@@ rtl/gae_mul.sv @@
// 64x64 product built from four 32x32 partial products, one per cycle.
module gae_mul import gae_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  mul_req_type  req,
   input  logic [63:0]  a,
   input  logic [63:0]  b,
   output logic         busy,
   output logic [127:0] prod
);

   logic         busy_ff, busy_in;
   logic [1:0]   idx_ff, idx_in;
   logic [63:0]  a_ff, a_in, b_ff, b_in;
   logic [127:0] acc_ff, acc_in;
   logic [31:0]  op_a, op_b;
   logic [63:0]  pp;
   logic [1:0]   sh;

   always_comb begin
      op_a = idx_ff[0] ? a_ff[63:32] : a_ff[31:0];
      op_b = idx_ff[1] ? b_ff[63:32] : b_ff[31:0];
      pp   = op_a * op_b;
      sh   = {1'b0, idx_ff[0]} + {1'b0, idx_ff[1]};
      busy_in = busy_ff;
      idx_in  = idx_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (req.start) begin
         busy_in = 1'b1;
         idx_in  = 2'd0;
         a_in    = a;
         b_in    = b;
         if (req.clear) begin
            acc_in = 128'd0;
         end
      end else if (busy_ff) begin
         acc_in = acc_ff + ({64'd0, pp} << {sh, 5'd0});
         idx_in = idx_ff + 2'd1;
         if (idx_ff == 2'd3) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign busy = busy_ff;
   assign prod = acc_ff;

endmodule

@@ rtl/gae_sqrt.sv @@
// floor(sqrt(v)), one root bit per cycle.
module gae_sqrt (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [127:0] v,
   output logic         busy,
   output logic [63:0]  root
);

   logic         busy_ff, busy_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic [127:0] v_ff, v_in;
   logic [66:0]  rem_ff, rem_in;
   logic [63:0]  root_ff, root_in;
   logic [66:0]  rem_sh;
   logic [66:0]  trial;

   always_comb begin
      rem_sh  = {rem_ff[64:0], v_ff[127:126]};
      trial   = {1'b0, root_ff, 2'b01};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      v_in    = v_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd0;
         v_in    = v;
         rem_in  = 67'd0;
         root_in = 64'd0;
      end else if (busy_ff) begin
         v_in = {v_ff[125:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[62:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      v_ff    <= v_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

@@ rtl/gae_div.sv @@
// Restoring divider, 63 quotient bits, one per cycle. The caller loads the
// partial remainder (already below the divisor) and the low dividend bits.
module gae_div (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [127:0] rem_init,
   input  logic [62:0]  low_bits,
   input  logic [127:0] divisor,
   output logic         busy,
   output logic [62:0]  quot
);

   logic         busy_ff, busy_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic [127:0] rem_ff, rem_in;
   logic [62:0]  low_ff, low_in;
   logic [127:0] d_ff, d_in;
   logic [62:0]  q_ff, q_in;
   logic [128:0] rem_sh;

   always_comb begin
      rem_sh  = {rem_ff, low_ff[62]};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      d_in    = d_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd0;
         rem_in  = rem_init;
         low_in  = low_bits;
         d_in    = divisor;
         q_in    = 63'd0;
      end else if (busy_ff) begin
         low_in = {low_ff[61:0], 1'b0};
         if (rem_sh >= {1'b0, d_ff}) begin
            rem_in = 128'(rem_sh - {1'b0, d_ff});
            q_in   = {q_ff[61:0], 1'b1};
         end else begin
            rem_in = rem_sh[127:0];
            q_in   = {q_ff[61:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd62) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      d_ff   <= d_in;
      q_ff   <= q_in;
   end

   assign busy = busy_ff;
   assign quot = q_ff;

endmodule

@@ rtl/gravity_accumulate_euler_step.sv @@
// One body's gravity accumulator and semi-implicit Euler integrator. Each
// item is taken only while the block is idle and gives one result item.
// Loads, commit and unused codes go straight to the result. A move makes six
// passes through the shared multiplier (start, four partial products, write
// back), three for velocity, then three for position; with can_move clear it
// goes straight to the result. An added body needs three squarings on the
// multiplier, the bit-serial square root and the pull division. Three
// unit-vector divisions share one divider, and three pull products use the
// multiplier. When the pull saturates, the pull division is skipped. A
// coinciding body skips the root and the divisions. A result waiting on
// rsp_tready holds the block before it goes idle again.
module gravity_accumulate_euler_step import gae_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [255:0] req_tdata,  // vec_x, vec_y, vec_z, grav_param, pad
   input  logic [2:0]   req_tuser,  // func
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [383:0] rsp_tdata,  // pos_x, pos_y, pos_z, acc_x, acc_y, acc_z
   output logic         rsp_tuser,  // zero_distance
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_index,
   input  logic [31:0]  csr_data
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DELTA = 4'd1;
   localparam logic [3:0] S_SQ    = 4'd2;
   localparam logic [3:0] S_SQ_W  = 4'd3;
   localparam logic [3:0] S_ZCHK  = 4'd4;
   localparam logic [3:0] S_SQRT  = 4'd5;
   localparam logic [3:0] S_GDIV  = 4'd6;
   localparam logic [3:0] S_GDV_W = 4'd7;
   localparam logic [3:0] S_UDIV  = 4'd8;
   localparam logic [3:0] S_UDV_W = 4'd9;
   localparam logic [3:0] S_GU    = 4'd10;
   localparam logic [3:0] S_GU_W  = 4'd11;
   localparam logic [3:0] S_MV    = 4'd12;
   localparam logic [3:0] S_MV_W  = 4'd13;
   localparam logic [3:0] S_FIN   = 4'd14;

   logic [3:0]  state_ff, state_in;
   logic [1:0]  comp_ff, comp_in;
   logic        phase_ff, phase_in;  // move: 0 velocity pass, 1 position pass
   logic [31:0] dt_ff, dt_in;
   logic        can_move_ff, can_move_in;
   logic [63:0] pos_ff [3];
   logic [63:0] pos_in [3];
   logic [63:0] vel_ff [3];
   logic [63:0] vel_in [3];
   logic [63:0] acc_ff [3];
   logic [63:0] acc_in [3];
   logic [63:0] sum_ff [3];
   logic [63:0] sum_in [3];
   logic [63:0] other_ff [3];
   logic [63:0] other_in [3];
   logic [63:0] dl_ff [3];
   logic [63:0] dl_in [3];
   logic [62:0] mu_ff, mu_in;
   logic [127:0] r2_ff, r2_in;
   logic [63:0] root_ff, root_in;
   logic [62:0] g_ff, g_in;
   logic [62:0] u_ff, u_in;
   logic        zero_ff, zero_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [383:0] rsp_data_ff, rsp_data_in;
   logic        rsp_user_ff, rsp_user_in;

   mul_req_type  mreq;
   logic [63:0]  mul_a, mul_b;
   logic         mul_busy;
   logic [127:0] mul_prod;
   logic         sqrt_start, sqrt_busy;
   logic [63:0]  sqrt_root;
   logic         div_start, div_busy;
   logic [127:0] div_rem, div_d;
   logic [62:0]  div_low, div_q;

   logic         accept;
   logic [63:0]  cur_mag;
   logic [63:0]  scaled;
   logic [63:0]  mv_src;
   logic [87:0]  mu_sh;

   gae_mul u_mul (
      .clock(clock), .reset(reset), .req(mreq), .a(mul_a), .b(mul_b),
      .busy(mul_busy), .prod(mul_prod)
   );

   gae_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sqrt_start), .v(r2_ff),
      .busy(sqrt_busy), .root(sqrt_root)
   );

   gae_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .rem_init(div_rem),
      .low_bits(div_low), .divisor(div_d), .busy(div_busy), .quot(div_q)
   );

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign mu_sh      = {mu_ff, 25'd0};
   assign cur_mag    = mag_of(dl_ff[comp_ff]);
   assign mv_src     = phase_ff ? vel_ff[comp_ff] : acc_ff[comp_ff];
   // magnitude * dt / 2^24, all ones when it does not fit
   assign scaled     = (|mul_prod[127:88]) ? {64{1'b1}} : mul_prod[87:24];

   always_comb begin
      state_in     = state_ff;
      comp_in      = comp_ff;
      phase_in     = phase_ff;
      dt_in        = dt_ff;
      can_move_in  = can_move_ff;
      pos_in       = pos_ff;
      vel_in       = vel_ff;
      acc_in       = acc_ff;
      sum_in       = sum_ff;
      other_in     = other_ff;
      dl_in        = dl_ff;
      mu_in        = mu_ff;
      r2_in        = r2_ff;
      root_in      = root_ff;
      g_in         = g_ff;
      u_in         = u_ff;
      zero_in      = zero_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      mreq         = '0;
      mul_a        = cur_mag;
      mul_b        = cur_mag;
      sqrt_start   = 1'b0;
      div_start    = 1'b0;
      div_rem      = {40'd0, mu_sh};
      div_low      = 63'd0;
      div_d        = r2_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_TIME_STEP: dt_in = csr_data;
            CSR_CAN_MOVE:  can_move_in = csr_data[0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               zero_in  = 1'b0;
               comp_in  = 2'd0;
               phase_in = 1'b0;
               state_in = S_FIN;
               case (req_tuser)
                  FUNC_LOAD_POS: begin
                     pos_in[0] = req_tdata[63:0];
                     pos_in[1] = req_tdata[127:64];
                     pos_in[2] = req_tdata[191:128];
                  end
                  FUNC_LOAD_VEL: begin
                     vel_in[0] = req_tdata[63:0];
                     vel_in[1] = req_tdata[127:64];
                     vel_in[2] = req_tdata[191:128];
                  end
                  FUNC_ADD_BODY: begin
                     other_in[0] = req_tdata[63:0];
                     other_in[1] = req_tdata[127:64];
                     other_in[2] = req_tdata[191:128];
                     mu_in       = req_tdata[254:192];
                     state_in    = S_DELTA;
                  end
                  FUNC_COMMIT: begin
                     acc_in = sum_ff;
                     for (int i = 0; i < 3; i++) begin
                        sum_in[i] = 64'd0;
                     end
                  end
                  FUNC_MOVE: begin
                     if (can_move_ff) begin
                        state_in = S_MV;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_DELTA: begin
            for (int i = 0; i < 3; i++) begin
               dl_in[i] = sat_sub(other_ff[i], pos_ff[i]);
            end
            state_in = S_SQ;
         end
         S_SQ: begin
            mreq.start = 1'b1;
            mreq.clear = (comp_ff == 2'd0);
            state_in   = S_SQ_W;
         end
         S_SQ_W: begin
            if (!mul_busy) begin
               if (comp_ff == 2'd2) begin
                  comp_in  = 2'd0;
                  r2_in    = mul_prod;
                  state_in = S_ZCHK;
               end else begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = S_SQ;
               end
            end
         end
         S_ZCHK: begin
            if (r2_ff == 128'd0) begin
               zero_in  = 1'b1;
               state_in = S_FIN;
            end else begin
               sqrt_start = 1'b1;
               state_in   = S_SQRT;
            end
         end
         S_SQRT: begin
            if (!sqrt_busy) begin
               root_in  = sqrt_root;
               state_in = S_GDIV;
            end
         end
         S_GDIV: begin
            // pull saturates when mu * 2^25 >= r^2
            if ({40'd0, mu_sh} >= r2_ff) begin
               g_in     = SMAX[62:0];
               state_in = S_UDIV;
            end else begin
               div_start = 1'b1;
               state_in  = S_GDV_W;
            end
         end
         S_GDV_W: begin
            if (!div_busy) begin
               g_in     = div_q;
               state_in = S_UDIV;
            end
         end
         S_UDIV: begin
            // component magnitude never exceeds the root, so no saturation
            div_rem   = {65'd0, cur_mag[63:1]};
            div_low   = {cur_mag[0], 62'd0};
            div_d     = {64'd0, root_ff};
            div_start = 1'b1;
            state_in  = S_UDV_W;
         end
         S_UDV_W: begin
            if (!div_busy) begin
               u_in     = div_q;
               state_in = S_GU;
            end
         end
         S_GU: begin
            mul_a      = {1'b0, g_ff};
            mul_b      = {1'b0, u_ff};
            mreq.start = 1'b1;
            mreq.clear = 1'b1;
            state_in   = S_GU_W;
         end
         S_GU_W: begin
            if (!mul_busy) begin
               sum_in[comp_ff] = sat_add(sum_ff[comp_ff],
                                         from_mag(dl_ff[comp_ff][63], mul_prod[125:62]));
               if (comp_ff == 2'd2) begin
                  state_in = S_FIN;
               end else begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = S_UDIV;
               end
            end
         end
         S_MV: begin
            mul_a      = mag_of(mv_src);
            mul_b      = {32'd0, dt_ff};
            mreq.start = 1'b1;
            mreq.clear = 1'b1;
            state_in   = S_MV_W;
         end
         S_MV_W: begin
            if (!mul_busy) begin
               if (phase_ff) begin
                  pos_in[comp_ff] = sat_add(pos_ff[comp_ff], from_mag(mv_src[63], scaled));
               end else begin
                  vel_in[comp_ff] = sat_add(vel_ff[comp_ff], from_mag(mv_src[63], scaled));
               end
               state_in = S_MV;
               if (comp_ff == 2'd2) begin
                  comp_in  = 2'd0;
                  phase_in = 1'b1;
                  if (phase_ff) begin
                     state_in = S_FIN;
                  end
               end else begin
                  comp_in = comp_ff + 2'd1;
               end
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {acc_ff[2], acc_ff[1], acc_ff[0],
                               pos_ff[2], pos_ff[1], pos_ff[0]};
               rsp_user_in  = zero_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         comp_ff      <= 2'd0;
         phase_ff     <= 1'b0;
         dt_ff        <= TIME_STEP_RESET;
         can_move_ff  <= 1'b1;
         zero_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= 64'd0;
            vel_ff[i] <= 64'd0;
            acc_ff[i] <= 64'd0;
            sum_ff[i] <= 64'd0;
         end
      end else begin
         state_ff     <= state_in;
         comp_ff      <= comp_in;
         phase_ff     <= phase_in;
         dt_ff        <= dt_in;
         can_move_ff  <= can_move_in;
         zero_ff      <= zero_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
         acc_ff       <= acc_in;
         sum_ff       <= sum_in;
      end
      other_ff    <= other_in;
      dl_ff       <= dl_in;
      mu_ff       <= mu_in;
      r2_ff       <= r2_in;
      root_ff     <= root_in;
      g_ff        <= g_in;
      u_ff        <= u_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
